@@ rtl/tofq_pkg.sv @@
// Shared types and constants for the timestamp-ordered frame queue.
package tofq_pkg;

    localparam int KEY_W     = 64;
    localparam int KIND_W    = 2;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // request codes
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH     = 2'd0,
        FN_POP      = 2'd1,
        FN_POP_KIND = 2'd2,
        FN_NONE     = 2'd3
    } t_func;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_PREBUF = 3'd3,
        ST_KIND   = 3'd4
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DECIDE = 3'd1,
        S_WALK   = 3'd2,
        S_PLACE  = 3'd3,
        S_HEAD   = 3'd4,
        S_DONE   = 3'd5
    } t_state;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREBUF_LEVEL = 1'd1;

    localparam logic [CFG_W-1:0] CAPACITY_RESET   = 7'd64;
    localparam logic [CFG_W-1:0] PREBUF_LVL_RESET = 7'd1;

endpackage

@@ rtl/timestamp_ordered_frame_queue_top.sv @@
// Top level of the timestamp-ordered frame queue: config registers, result register.
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_ready   i_func, i_stamp, i_frame_handle, i_media_kind
//  result    out        o_out_valid / i_out_ready o_status, o_out_handle, o_out_stamp,
//                                                 o_out_kind, o_fill_count, o_prebuffering
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item at a time. A push into a non-empty queue walks back from the tail over the k held
// entries with a later stamp, moving one entry per cycle, then writes the new entry into the freed slot.
// Pops that reach the head read it, kind mismatch included; refused pushes, pushes into an
// empty queue, empty pops, kind pops while prebuffering and ignored requests go straight to the result.
// Reset is synchronous, active low: empty, prebuffering, capacity 64, level 1; store not cleared.
// A stalled result waits in the output register; the next item is accepted meanwhile.
module timestamp_ordered_frame_queue_top #(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [tofq_pkg::FUNC_W-1:0]         i_func,
    input  logic [tofq_pkg::KEY_W-1:0]          i_stamp,
    input  logic [TAG_BITS-1:0]                 i_frame_handle,
    input  logic [tofq_pkg::KIND_W-1:0]         i_media_kind,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tofq_pkg::STATUS_W-1:0]       o_status,
    output logic [TAG_BITS-1:0]                 o_out_handle,
    output logic [tofq_pkg::KEY_W-1:0]          o_out_stamp,
    output logic [tofq_pkg::KIND_W-1:0]         o_out_kind,
    output logic [$clog2(DEPTH+1)-1:0]          o_fill_count,
    output logic                                o_prebuffering,
    // configuration port
    input  logic                                i_cfg_we,
    input  logic [tofq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tofq_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int EW = tofq_pkg::KEY_W + TAG_BITS + tofq_pkg::KIND_W;

    logic [tofq_pkg::CFG_W-1:0] r_capacity;
    logic [tofq_pkg::CFG_W-1:0] r_prebuf_level;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [EW-1:0]         mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [EW-1:0]         mem_rdata;

    logic                          res_valid;
    logic                          res_take;
    logic [tofq_pkg::STATUS_W-1:0] res_status;
    logic [TAG_BITS-1:0]           res_handle;
    logic [tofq_pkg::KEY_W-1:0]    res_stamp;
    logic [tofq_pkg::KIND_W-1:0]   res_kind;
    logic [CW-1:0]                 res_fill;
    logic                          res_prebuf;

    logic                          r_out_valid;
    logic [tofq_pkg::STATUS_W-1:0] r_status;
    logic [TAG_BITS-1:0]           r_handle;
    logic [tofq_pkg::KEY_W-1:0]    r_stamp;
    logic [tofq_pkg::KIND_W-1:0]   r_kind;
    logic [CW-1:0]                 r_fill;
    logic                          r_prebuf;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity     <= tofq_pkg::CAPACITY_RESET;
            r_prebuf_level <= tofq_pkg::PREBUF_LVL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tofq_pkg::REG_CAPACITY:     r_capacity     <= i_cfg_data;
                tofq_pkg::REG_PREBUF_LEVEL: r_prebuf_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tofq_store #(
        .DEPTH (DEPTH),
        .EW    (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tofq_ctrl #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_stamp        (i_stamp),
        .i_handle       (i_frame_handle),
        .i_kind         (i_media_kind),
        .i_capacity     (r_capacity),
        .i_prebuf_level (r_prebuf_level),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata),
        .o_res_valid    (res_valid),
        .i_res_take     (res_take),
        .o_res_status   (res_status),
        .o_res_handle   (res_handle),
        .o_res_stamp    (res_stamp),
        .o_res_kind     (res_kind),
        .o_res_fill     (res_fill),
        .o_res_prebuf   (res_prebuf)
    );

    // output register: loads when empty or being drained
    assign res_take = res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_status <= res_status;
            r_handle <= res_handle;
            r_stamp  <= res_stamp;
            r_kind   <= res_kind;
            r_fill   <= res_fill;
            r_prebuf <= res_prebuf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_handle   = r_handle;
    assign o_out_stamp    = r_stamp;
    assign o_out_kind     = r_kind;
    assign o_fill_count   = r_fill;
    assign o_prebuffering = r_prebuf;

endmodule

@@ rtl/tofq_store.sv @@
// Entry memory: one write port, one read port with registered read data.
module tofq_store #(
    parameter int DEPTH = 64,
    parameter int EW    = 82
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [EW-1:0]              i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [EW-1:0]              o_rdata
);

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, read every cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tofq_ctrl.sv @@
// Sequencer: sorted insert by tail walk, head removal, status and fill tracking.
module tofq_ctrl #(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    // request side
    input  logic                                         i_in_valid,
    output logic                                         o_in_ready,
    input  logic [tofq_pkg::FUNC_W-1:0]                  i_func,
    input  logic [tofq_pkg::KEY_W-1:0]                   i_stamp,
    input  logic [TAG_BITS-1:0]                          i_handle,
    input  logic [tofq_pkg::KIND_W-1:0]                  i_kind,
    // configuration
    input  logic [tofq_pkg::CFG_W-1:0]                   i_capacity,
    input  logic [tofq_pkg::CFG_W-1:0]                   i_prebuf_level,
    // entry memory
    output logic                                         o_mem_we,
    output logic [$clog2(DEPTH)-1:0]                     o_mem_waddr,
    output logic [tofq_pkg::KEY_W+TAG_BITS+tofq_pkg::KIND_W-1:0] o_mem_wdata,
    output logic [$clog2(DEPTH)-1:0]                     o_mem_raddr,
    input  logic [tofq_pkg::KEY_W+TAG_BITS+tofq_pkg::KIND_W-1:0] i_mem_rdata,
    // result side
    output logic                                         o_res_valid,
    input  logic                                         i_res_take,
    output logic [tofq_pkg::STATUS_W-1:0]                o_res_status,
    output logic [TAG_BITS-1:0]                          o_res_handle,
    output logic [tofq_pkg::KEY_W-1:0]                   o_res_stamp,
    output logic [tofq_pkg::KIND_W-1:0]                  o_res_kind,
    output logic [$clog2(DEPTH+1)-1:0]                   o_res_fill,
    output logic                                         o_res_prebuf
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH+1);
    localparam int CMPW = (CW > tofq_pkg::CFG_W) ? CW : tofq_pkg::CFG_W;
    localparam int KW   = tofq_pkg::KEY_W;
    localparam int DW   = tofq_pkg::KIND_W;
    localparam int EW   = KW + TAG_BITS + DW;
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);
    localparam logic [AW:0]     DEPTH_S = (AW+1)'(DEPTH);
    localparam logic [AW-1:0]   LAST    = AW'(DEPTH-1);

    // logical position to memory address in the circular store
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    tofq_pkg::t_state  r_state, n_state;
    tofq_pkg::t_func   r_func, n_func;
    logic [KW-1:0]     r_stamp, n_stamp;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic [DW-1:0]     r_kind, n_kind;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic              r_filling, n_filling;
    tofq_pkg::t_status r_res_status, n_res_status;
    logic [TAG_BITS-1:0] r_res_tag, n_res_tag;
    logic [KW-1:0]     r_res_stamp, n_res_stamp;
    logic [DW-1:0]     r_res_kind, n_res_kind;

    logic [KW-1:0]       rd_key;
    logic [TAG_BITS-1:0] rd_tag;
    logic [DW-1:0]       rd_kind;
    logic [EW-1:0]       new_entry;
    logic [CMPW-1:0]     cnt_ext;
    logic [CW-1:0]       count_inc, count_dec, count_m1;
    logic                is_full, reach_level, later_key;
    logic [AW-1:0]       idx_up, idx_dn, head_inc;

    // field split of the read entry, shared compare
    assign rd_key    = i_mem_rdata[EW-1 -: KW];
    assign rd_tag    = i_mem_rdata[DW +: TAG_BITS];
    assign rd_kind   = i_mem_rdata[DW-1:0];
    assign new_entry = {r_stamp, r_tag, r_kind};
    assign later_key = rd_key > r_stamp;

    assign cnt_ext     = CMPW'(r_count);
    assign count_inc   = r_count + 1'b1;
    assign count_dec   = r_count - 1'b1;
    assign count_m1    = r_count - 1'b1;
    assign is_full     = (cnt_ext >= DEPTH_C) || (cnt_ext >= CMPW'(i_capacity));
    assign reach_level = CMPW'(count_inc) >= CMPW'(i_prebuf_level);
    assign idx_up      = r_idx + 1'b1;
    assign idx_dn      = r_idx - 1'b1;
    assign head_inc    = (r_head == LAST) ? '0 : r_head + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tofq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tofq_pkg::S_DECIDE;
                end
            end
            tofq_pkg::S_DECIDE: begin
                case (r_func)
                    tofq_pkg::FN_PUSH: begin
                        if (is_full || r_count == '0) begin
                            n_state = tofq_pkg::S_DONE;
                        end else begin
                            n_state = tofq_pkg::S_WALK;
                        end
                    end
                    tofq_pkg::FN_POP: begin
                        n_state = (r_count == '0) ? tofq_pkg::S_DONE : tofq_pkg::S_HEAD;
                    end
                    tofq_pkg::FN_POP_KIND: begin
                        if (r_count == '0 || r_filling) begin
                            n_state = tofq_pkg::S_DONE;
                        end else begin
                            n_state = tofq_pkg::S_HEAD;
                        end
                    end
                    default: n_state = tofq_pkg::S_DONE;
                endcase
            end
            tofq_pkg::S_WALK: begin
                if (!later_key) begin
                    n_state = tofq_pkg::S_DONE;
                end else if (r_idx == '0) begin
                    n_state = tofq_pkg::S_PLACE;
                end
            end
            tofq_pkg::S_PLACE: n_state = tofq_pkg::S_DONE;
            tofq_pkg::S_HEAD:  n_state = tofq_pkg::S_DONE;
            tofq_pkg::S_DONE: begin
                if (i_res_take) begin
                    n_state = tofq_pkg::S_IDLE;
                end
            end
            default: n_state = tofq_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control per state
    always_comb begin
        n_func       = r_func;
        n_stamp      = r_stamp;
        n_tag        = r_tag;
        n_kind       = r_kind;
        n_idx        = r_idx;
        n_head       = r_head;
        n_count      = r_count;
        n_filling    = r_filling;
        n_res_status = r_res_status;
        n_res_tag    = r_res_tag;
        n_res_stamp  = r_res_stamp;
        n_res_kind   = r_res_kind;
        o_mem_we     = 1'b0;
        o_mem_waddr  = f_phys(r_head, idx_up);
        o_mem_wdata  = new_entry;
        o_mem_raddr  = r_head;
        case (r_state)
            tofq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = tofq_pkg::t_func'(i_func);
                    n_stamp = i_stamp;
                    n_tag   = i_handle;
                    n_kind  = i_kind;
                end
            end
            tofq_pkg::S_DECIDE: begin
                n_res_status = tofq_pkg::ST_OK;
                n_res_tag    = '0;
                n_res_stamp  = '0;
                n_res_kind   = '0;
                n_idx        = count_m1[AW-1:0];
                case (r_func)
                    tofq_pkg::FN_PUSH: begin
                        // start the walk at the tail
                        o_mem_raddr = f_phys(r_head, count_m1[AW-1:0]);
                        if (is_full) begin
                            n_res_status = tofq_pkg::ST_FULL;
                        end else if (r_count == '0) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = r_head;
                            n_count     = count_inc;
                            if (reach_level) begin
                                n_filling = 1'b0;
                            end
                        end
                    end
                    tofq_pkg::FN_POP: begin
                        if (r_count == '0) begin
                            n_res_status = tofq_pkg::ST_EMPTY;
                        end
                    end
                    tofq_pkg::FN_POP_KIND: begin
                        if (r_count == '0) begin
                            n_res_status = tofq_pkg::ST_EMPTY;
                        end else if (r_filling) begin
                            n_res_status = tofq_pkg::ST_PREBUF;
                        end
                    end
                    default: ;
                endcase
            end
            tofq_pkg::S_WALK: begin
                // move a later entry up one slot, or drop the new one in behind it
                o_mem_raddr = f_phys(r_head, idx_dn);
                o_mem_we    = 1'b1;
                if (later_key) begin
                    o_mem_wdata = i_mem_rdata;
                    n_idx       = idx_dn;
                end else begin
                    n_count = count_inc;
                    if (reach_level) begin
                        n_filling = 1'b0;
                    end
                end
            end
            tofq_pkg::S_PLACE: begin
                // every held entry is later: new entry becomes the head
                o_mem_we    = 1'b1;
                o_mem_waddr = r_head;
                n_count     = count_inc;
                if (reach_level) begin
                    n_filling = 1'b0;
                end
            end
            tofq_pkg::S_HEAD: begin
                if (r_func == tofq_pkg::FN_POP_KIND && rd_kind != r_kind) begin
                    n_res_status = tofq_pkg::ST_KIND;
                end else begin
                    n_res_tag   = rd_tag;
                    n_res_stamp = rd_key;
                    n_res_kind  = rd_kind;
                    n_head      = head_inc;
                    n_count     = count_dec;
                    if (count_dec == '0) begin
                        n_filling = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tofq_pkg::S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_filling <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_filling <= n_filling;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_stamp      <= n_stamp;
        r_tag        <= n_tag;
        r_kind       <= n_kind;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_tag    <= n_res_tag;
        r_res_stamp  <= n_res_stamp;
        r_res_kind   <= n_res_kind;
    end

    assign o_in_ready   = (r_state == tofq_pkg::S_IDLE);
    assign o_res_valid  = (r_state == tofq_pkg::S_DONE);
    assign o_res_status = r_res_status;
    assign o_res_handle = r_res_tag;
    assign o_res_stamp  = r_res_stamp;
    assign o_res_kind   = r_res_kind;
    assign o_res_fill   = r_count;
    assign o_res_prebuf = r_filling;

    // fill never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_ext <= DEPTH_C)
        else $error("entry count above depth");

    // the walk stays inside the held entries
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tofq_pkg::S_WALK) |-> (CMPW'(r_idx) < cnt_ext))
        else $error("walk index outside held entries");

    // an empty queue is always prebuffering
    a_empty_filling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> r_filling)
        else $error("empty queue not prebuffering");

    // a head read only happens with entries held
    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tofq_pkg::S_HEAD) |-> (r_count != '0))
        else $error("head removal from empty queue");

endmodule
